### src/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PROD_W    = 2 * DATA_W;
  // Truncated product plus growth for a DIM-term sum.
  localparam int ACC_W     = PROD_W - FRAC_BITS + $clog2(DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### src/mm4_store.sv
// Left and right operand stores, DIM x DIM elements each, reset to zero.
// One write port shared by both stores, one read port per store. Uses mm4_pkg.
`default_nettype none

module mm4_store (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic                         wr_sel_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]    wr_row_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]    wr_col_i,
  input  wire logic [mm4_pkg::DATA_W-1:0]   wr_data_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]    rd_row_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]    rd_col_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]    rd_k_i,
  output logic      [mm4_pkg::DATA_W-1:0]   left_o,
  output logic      [mm4_pkg::DATA_W-1:0]   right_o
);
  import mm4_pkg::*;

  logic [DATA_W-1:0] left_q  [DIM][DIM];
  logic [DATA_W-1:0] right_q [DIM][DIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          left_q[i][j]  <= '0;
          right_q[i][j] <= '0;
        end
      end
    end else if (wr_en_i) begin
      if (wr_sel_i) begin
        right_q[wr_row_i][wr_col_i] <= wr_data_i;
      end else begin
        left_q[wr_row_i][wr_col_i] <= wr_data_i;
      end
    end
  end

  assign left_o  = left_q[rd_row_i][rd_k_i];
  assign right_o = right_q[rd_k_i][rd_col_i];

endmodule

`default_nettype wire

### src/mm4_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, floor shift,
// wide accumulator and 32-bit saturation. Uses mm4_pkg.
`default_nettype none

module mm4_mac (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mm4_pkg::mac_ctrl_t          ctrl_i,
  input  wire logic [mm4_pkg::DATA_W-1:0]  a_i,
  input  wire logic [mm4_pkg::DATA_W-1:0]  b_i,
  output logic      [mm4_pkg::DATA_W-1:0]  sat_o
);
  import mm4_pkg::*;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     fits;

  assign prod_d  = PROD_W'($signed(a_i)) * PROD_W'($signed(b_i));
  // Arithmetic shift rounds toward minus infinity.
  assign prod_sh = prod_q >>> FRAC_BITS;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + ACC_W'(prod_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // The sum fits when all bits above bit 31 copy the sign.
  assign fits = (acc_q[ACC_W-1:DATA_W-1] == '0) || (acc_q[ACC_W-1:DATA_W-1] == '1);

  always_comb begin
    if (fits) begin
      sat_o = acc_q[DATA_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sat_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

### src/mm4_ctrl.sv
// Sequencer for the product burst: walks row, column and inner index,
// drives the shared MAC and hands each element to the output register. Uses mm4_pkg.
`default_nettype none

module mm4_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_last_i,
  output logic                            in_ready_o,
  input  wire logic                       out_free_i,
  output logic                            out_load_o,
  output logic                            out_final_o,
  output logic     [mm4_pkg::IDX_W-1:0]   r_o,
  output logic     [mm4_pkg::IDX_W-1:0]   c_o,
  output logic     [mm4_pkg::IDX_W-1:0]   k_o,
  output mm4_pkg::mac_ctrl_t              mac_o
);
  import mm4_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DIM - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] r_q, c_q, k_q;
  logic             pv_q;
  logic             start;
  logic             is_final;

  assign start    = (state_q == ST_IDLE) && in_valid_i && in_last_i;
  assign is_final = (r_q == LastIdx) && (c_q == LastIdx);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (k_q == LastIdx) state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (out_free_i) state_d = is_final ? ST_IDLE : ST_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    out_load_o    = (state_q == ST_PUT) && out_free_i;
    mac_o.clear   = start || out_load_o;
    mac_o.mul_en  = (state_q == ST_MUL);
    mac_o.acc_en  = pv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == ST_MUL);
      if (start) begin
        r_q <= '0;
        c_q <= '0;
        k_q <= '0;
      end
      if (state_q == ST_MUL) begin
        k_q <= (k_q == LastIdx) ? '0 : k_q + 1'b1;
      end
      if (out_load_o) begin
        if (c_q == LastIdx) begin
          c_q <= '0;
          r_q <= (r_q == LastIdx) ? '0 : r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  assign r_o         = r_q;
  assign c_o         = c_q;
  assign k_o         = k_q;
  assign out_final_o = is_final;

endmodule

`default_nettype wire

### src/matrix4x4_multiply.sv
// Top level of the 4x4 signed Q16.16 matrix multiplier: operand stores,
// shared MAC, sequencer and output register. Uses mm4_pkg and all mm4_* modules.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | op_i row_i col_i value_i last_i
//   out     | output    | out_valid_o/out_ready_i | out_row_o out_col_o product_o
//           |           |                        | final_res_o
//
// A word with last starts a burst of DIM*DIM results, computed one after
// another through the single multiplier and accumulator. Input is not taken
// during a burst. Output stalls hold the sequencer in its hand-off step.
// Reset clears both stores to zero and the control state.
`default_nettype none

module matrix4x4_multiply (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        op_i,
  input  wire logic [1:0]  row_i,
  input  wire logic [1:0]  col_i,
  input  wire logic [31:0] value_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  out_row_o,
  output logic      [1:0]  out_col_o,
  output logic      [31:0] product_o,
  output logic             final_res_o
);
  import mm4_pkg::*;

  logic              in_accept;
  logic              wr_ok;
  logic              out_free;
  logic              out_load;
  logic              out_final;
  logic [IDX_W-1:0]  r_idx, c_idx, k_idx;
  logic [DATA_W-1:0] left_el, right_el, sat;
  mac_ctrl_t         mac_ctrl;

  logic              out_valid_q;
  logic [1:0]        out_row_q, out_col_q;
  logic [DATA_W-1:0] product_q;
  logic              final_q;

  assign in_accept = in_valid_i && in_ready_o;
  // Indices outside the matrix leave the stores untouched.
  assign wr_ok     = (int'(row_i) < DIM) && (int'(col_i) < DIM);
  assign out_free  = !out_valid_q || out_ready_i;

  mm4_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_accept && wr_ok),
    .wr_sel_i  (op_i),
    .wr_row_i  (IDX_W'(row_i)),
    .wr_col_i  (IDX_W'(col_i)),
    .wr_data_i (value_i),
    .rd_row_i  (r_idx),
    .rd_col_i  (c_idx),
    .rd_k_i    (k_idx),
    .left_o    (left_el),
    .right_o   (right_el)
  );

  mm4_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (left_el),
    .b_i    (right_el),
    .sat_o  (sat)
  );

  mm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_i),
    .in_ready_o  (in_ready_o),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_final_o (out_final),
    .r_o         (r_idx),
    .c_o         (c_idx),
    .k_o         (k_idx),
    .mac_o       (mac_ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q <= 2'(r_idx);
      out_col_q <= 2'(c_idx);
      product_q <= sat;
      final_q   <= out_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign product_o   = product_q;
  assign final_res_o = final_q;

endmodule

`default_nettype wire
